### hw/rtl/gml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gml_pkg
// Types, character codes and per-byte update functions of the menu line
// parser.
// ----------------------------------------------------------------------------
package gml_pkg;

	localparam int PORT_TEXT_BYTES = 16;
	localparam int PORT_SEEN_W     = $clog2(PORT_TEXT_BYTES);
	localparam int SLOTS           = 4;
	localparam int SLOT_CNT_W      = $clog2(SLOTS + 1);

	localparam logic [15:0] DEFAULT_PORT_RESET = 16'd70;
	localparam logic [15:0] COUNT_MAX          = 16'hFFFF;
	localparam logic [16:0] PORT_CAP           = 17'd65536;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_VT_LO = 8'h09;
	localparam logic [7:0] CH_VT_HI = 8'h0D;

	localparam logic [1:0] FIELD_PORT = 2'd3;

	typedef enum logic [2:0] {
		KIND_DISPLAY    = 3'd0,
		KIND_SELECTOR   = 3'd1,
		KIND_HOST       = 3'd2,
		KIND_RECORD_END = 3'd3,
		KIND_DONE       = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		LINE_EMPTY = 2'd0,
		LINE_HELD  = 2'd1,
		LINE_MORE  = 2'd2
	} line_phase_t;

	typedef enum logic [1:0] {
		PORT_SKIP   = 2'd0,
		PORT_SIGN   = 2'd1,
		PORT_DIGITS = 2'd2,
		PORT_STOP   = 2'd3
	} port_phase_t;

	typedef struct packed {
		line_phase_t             line_phase;
		logic [7:0]              held;
		logic                    has_tab;
		logic [1:0]              field;
		logic                    cr_pend;
		port_phase_t             pphase;
		logic                    neg;
		logic [16:0]             acc;
		logic [PORT_SEEN_W-1:0]  seen;
		logic [15:0]             total;
		logic                    term;
	} line_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [7:0]  item_type;
		logic        flag;
		logic [15:0] port;
		logic [15:0] count;
		logic        last;
	} res_t;

	typedef struct packed {
		res_t [SLOTS-1:0]      slot;
		logic [SLOT_CNT_W-1:0] count;
	} step_out_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {[CH_VT_LO:CH_VT_HI], CH_SPACE});
	endfunction

	function automatic line_state_t clear_line(input line_state_t st);
		line_state_t s;
		s       = '0;
		s.total = st.total;
		s.term  = st.term;
		return s;
	endfunction

	function automatic line_state_t port_feed(input line_state_t st, input logic [7:0] c);
		line_state_t s;
		logic        go;
		logic [20:0] prod;
		s    = st;
		go   = 1'b0;
		prod = '0;
		if (s.seen < PORT_SEEN_W'(PORT_TEXT_BYTES - 1)) begin
			s.seen = s.seen + 1'b1;
			case (s.pphase)
				PORT_SKIP: begin
					if (!is_space(c)) begin
						if (c == CH_MINUS || c == CH_PLUS) begin
							s.neg    = (c == CH_MINUS);
							s.pphase = PORT_SIGN;
						end else begin
							s.pphase = PORT_DIGITS;
							go       = 1'b1;
						end
					end
				end
				PORT_SIGN: begin
					s.pphase = PORT_DIGITS;
					go       = 1'b1;
				end
				PORT_DIGITS: go = 1'b1;
				default: go = 1'b0;
			endcase
			if (go) begin
				if (c inside {[CH_ZERO:CH_NINE]}) begin
					prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1)
						+ {13'b0, c - CH_ZERO};
					s.acc = (prod > {4'b0, PORT_CAP}) ? PORT_CAP : prod[16:0];
				end else begin
					s.pphase = PORT_STOP;
				end
			end
		end
		return s;
	endfunction

	function automatic void feed_char(input line_state_t st, input logic [7:0] c,
			output line_state_t so, output res_t r, output logic e);
		line_state_t s;
		s = st;
		r = '0;
		e = 1'b0;
		if (s.line_phase == LINE_EMPTY) begin
			s.held       = c;
			s.has_tab    = (c == CH_TAB);
			s.line_phase = LINE_HELD;
		end else begin
			s.line_phase = LINE_MORE;
			if (s.field != FIELD_PORT) begin
				if (c == CH_TAB) begin
					s.field   = s.field + 1'b1;
					s.has_tab = 1'b1;
				end else begin
					e      = 1'b1;
					r.kind = kind_t'({1'b0, s.field});
					r.data = c;
				end
			end else begin
				s = port_feed(s, c);
			end
		end
		so = s;
	endfunction

	function automatic void end_line(input line_state_t st, input logic [15:0] dport,
			output line_state_t so, output res_t r, output logic e);
		line_state_t s;
		logic [15:0] port;
		s    = st;
		r    = '0;
		e    = 1'b0;
		port = dport;
		if (s.line_phase == LINE_HELD && s.held == CH_DOT) begin
			s.term = 1'b1;
		end else if (s.line_phase != LINE_EMPTY) begin
			if (s.field == FIELD_PORT && !s.neg && s.acc >= 17'd1
					&& s.acc <= {1'b0, COUNT_MAX})
				port = s.acc[15:0];
			if (s.total != COUNT_MAX)
				s.total = s.total + 1'b1;
			e           = 1'b1;
			r.kind      = KIND_RECORD_END;
			r.data      = s.held;
			r.item_type = s.has_tab ? s.held : CH_I;
			r.flag      = !s.has_tab;
			r.port      = port;
			r.count     = s.total;
		end
		so = clear_line(s);
	endfunction

endpackage

### hw/rtl/gopher_menu_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gopher_menu_line_parser
// Streaming gopher menu parser: bytes in, tagged field bytes, record ends and
// a done item out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one reply byte and end_of_buffer
// per transaction. Output channel out_valid/out_ready carries one result per
// transaction; last marks the final result caused by a byte.
// cfg_valid/cfg_ready writes default_port; cfg_ready is always high, and it
// should only be written while the parser is idle.
// A byte yields zero to four results. They are held in a four-entry result
// queue and appear from the cycle after the byte is taken, one per cycle
// unless stalled. A byte is taken when the queue is empty or its final entry
// leaves in the same cycle, so a byte's results all leave before the next's;
// bytes with at most one result stream at one per cycle unless stalled.
// A receiver stall holds the queue and, once it holds results, the input.
// Reset clears all parse state and the queue and sets default_port to 70.
// An end_of_buffer byte ends the reply: after its done item the parse state
// returns to its reset value, default_port excepted.
// ----------------------------------------------------------------------------
module gopher_menu_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  out_byte,
	output logic [7:0]  item_type,
	output logic        type_char_in_display,
	output logic [15:0] item_port,
	output logic [15:0] item_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] default_port
);
	import gml_pkg::*;

	logic [15:0]           default_port_q;
	res_t [SLOTS-1:0]      queue_q;
	logic [SLOT_CNT_W-1:0] cnt_q;
	step_out_t             step;
	logic                  in_fire;
	logic                  out_fire;

	assign cfg_ready = 1'b1;
	assign out_valid = (cnt_q != '0);
	assign out_fire  = out_valid && out_ready;
	assign in_ready  = (cnt_q == '0) || (out_ready && cnt_q == SLOT_CNT_W'(1));
	assign in_fire   = in_valid && in_ready;

	gml_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_fire),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.default_port  (default_port_q),
		.step          (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_port_q <= DEFAULT_PORT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			default_port_q <= default_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire) begin
			cnt_q <= step.count;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			queue_q <= step.slot;
		end else if (out_fire) begin
			queue_q <= {res_t'('0), queue_q[SLOTS-1:1]};
		end
	end

	assign kind                 = queue_q[0].kind;
	assign out_byte             = queue_q[0].data;
	assign item_type            = queue_q[0].item_type;
	assign type_char_in_display = queue_q[0].flag;
	assign item_port            = queue_q[0].port;
	assign item_count           = queue_q[0].count;
	assign last                 = queue_q[0].last;

	a_last_is_final_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (cnt_q == SLOT_CNT_W'(1))))
		else $error("last flag does not match final queued result");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_DONE) |-> last)
		else $error("done item not marked last");

	a_record_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_RECORD_END) |-> (item_count != 16'd0))
		else $error("record end with zero count");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (cnt_q == $past(cnt_q)))
		else $error("result queue changed while stalled");

endmodule

### hw/rtl/gml_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gml_core
// Line state registers and the per-byte update that produces up to four
// ordered results for one accepted byte.
// ----------------------------------------------------------------------------
module gml_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               end_of_buffer,
	input  logic [15:0]        default_port,
	output gml_pkg::step_out_t step
);
	import gml_pkg::*;

	line_state_t state_q;
	line_state_t f0_s, f1_s, f2_s;
	line_state_t s1, s2, s2b, s3, s_next;
	res_t        f0_r, f1_r, f2_r;
	logic        f0_e, f1_e, f2_e;
	logic        use_f0, use_f1, use_f2;
	res_t [SLOTS-1:0] cand;
	logic [SLOTS-1:0] en;
	logic [SLOT_CNT_W-1:0] n;

	always_comb begin
		use_f0 = !state_q.term && state_q.cr_pend && data_byte != CH_LF;
		feed_char(state_q, CH_CR, f0_s, f0_r, f0_e);
		s1 = use_f0 ? f0_s : state_q;

		use_f1 = !state_q.term && data_byte != CH_LF && data_byte != CH_CR;
		feed_char(s1, data_byte, f1_s, f1_r, f1_e);
		s2 = use_f1 ? f1_s : s1;

		s2b = s2;
		if (!state_q.term) begin
			if (data_byte == CH_CR)
				s2b.cr_pend = 1'b1;
			else if (data_byte != CH_LF)
				s2b.cr_pend = 1'b0;
		end

		use_f2 = !state_q.term && (data_byte == CH_LF || end_of_buffer);
		end_line(s2b, default_port, f2_s, f2_r, f2_e);
		s3 = use_f2 ? f2_s : s2b;

		s_next = end_of_buffer ? line_state_t'('0) : s3;

		en[0]   = use_f0 && f0_e;
		en[1]   = use_f1 && f1_e;
		en[2]   = use_f2 && f2_e;
		en[3]   = end_of_buffer;
		cand[0] = f0_r;
		cand[1] = f1_r;
		cand[2] = f2_r;
		cand[3] = '0;
		cand[3].kind  = KIND_DONE;
		cand[3].count = s3.total;
		cand[0].last  = !(en[1] || en[2] || en[3]);
		cand[1].last  = !(en[2] || en[3]);
		cand[2].last  = !en[3];
		cand[3].last  = 1'b1;
	end

	// pack enabled results in order
	always_comb begin
		step.slot = '0;
		n         = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (en[i]) begin
				step.slot[n[$clog2(SLOTS)-1:0]] = cand[i];
				n = n + 1'b1;
			end
		end
		step.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= s_next;
		end
	end

endmodule
